### rtl/core/assert_macros.svh
// assert_macros.svh - concurrent assertion macros shared by the RTL.
// Expects clk_i and rst_ni in the scope of the module that uses them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### rtl/core/hsv2rgb_pkg.sv
// hsv2rgb_pkg - field widths and defaults for the HSV to RGB converter.
// No dependencies.
`default_nettype none

package hsv2rgb_pkg;

  localparam int unsigned HueW           = 17;
  localparam int unsigned FracW          = 9;
  localparam int unsigned ByteW          = 8;
  localparam int unsigned HueFracBitsDef = 6;

endpackage

`default_nettype wire

### rtl/core/hsv_to_rgb_convert_core.sv
// hsv_to_rgb_convert_core - pipelined HSV to 8-bit RGB pixel converter.
// Depends on hsv2rgb_pkg and assert_macros.svh.
//
//   channel  | direction | handshake               | payload
//   ---------+-----------+-------------------------+-----------------------------
//   in       | sink      | in_valid_i / in_ready_o | hue_i, saturation_i, brightness_i
//   out      | source    | out_valid_o/out_ready_i | red_o, green_o, blue_o
//
// Twelve register stages; one request enters per cycle while back-pressure does not stall the pipeline.
// The depth is set by the two constant-reciprocal divisions (hue wrap, x channel).
// Each stage holds its own valid bit and stalls only when it and all later
// stages are full, so bubbles are squeezed out under back-pressure.
// Reset clears the valid bits only.
`default_nettype none
`include "assert_macros.svh"

module hsv_to_rgb_convert_core #(
  parameter int unsigned HueFracBits = hsv2rgb_pkg::HueFracBitsDef
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   in_valid_i,
  output logic                                   in_ready_o,
  input  logic signed [hsv2rgb_pkg::HueW-1:0]    hue_i,
  input  logic        [hsv2rgb_pkg::FracW-1:0]   saturation_i,
  input  logic        [hsv2rgb_pkg::FracW-1:0]   brightness_i,
  output logic                                   out_valid_o,
  input  logic                                   out_ready_i,
  output logic        [hsv2rgb_pkg::ByteW-1:0]   red_o,
  output logic        [hsv2rgb_pkg::ByteW-1:0]   green_o,
  output logic        [hsv2rgb_pkg::ByteW-1:0]   blue_o
);

  import hsv2rgb_pkg::*;

  localparam int unsigned NS     = 12;
  localparam int unsigned Unit   = 60 << HueFracBits;
  localparam int unsigned Turn   = 6 * Unit;
  localparam int unsigned TurnW  = $clog2(Turn + 1);
  localparam int unsigned UnitW  = $clog2(Unit + 1);
  localparam int unsigned Kt     = (65536 + Turn - 1) / Turn;
  localparam int unsigned HpMax  = 65535 + Kt * Turn;
  localparam int unsigned HpW    = $clog2(HpMax + 1);
  localparam longint unsigned Rec1 = (64'd1 << HpW) / Turn;
  localparam int unsigned CW     = 2 * FracW;
  localparam int unsigned MW     = CW + 1;
  localparam longint unsigned MaxN = 64'd511 * 511 * Unit + 64'd511 * 256 * Unit;
  localparam int unsigned NW     = $clog2(MaxN + 1) + 1;
  localparam longint unsigned AMax = (MaxN * 255) >> 16;
  localparam int unsigned AW     = $clog2(AMax + 1);
  localparam longint unsigned SatLim = 64'd256 * Unit;
  localparam int unsigned AW2    = $clog2(SatLim);
  localparam int unsigned S2     = AW2 + UnitW;
  localparam longint unsigned Rec2 = (64'd1 << S2) / Unit;
  localparam int unsigned RecW2  = AW2 + 1;
  localparam int unsigned PW2    = AW2 + RecW2;
  localparam logic [ByteW-1:0] ByteMax = '1;

  typedef enum logic [2:0] {
    SecRY, SecYG, SecGC, SecCB, SecBM, SecMR
  } sector_e;

  logic [NS-1:0] vld_q, en;

  // stage registers
  logic [HpW-1:0]        hp0_q, hp1_q, q1_q, r2_q;
  logic                  pos0_q, pos1_q, pos2_q;
  logic [CW-1:0]         c0_q, c1_q, c2_q, c3_q, c4_q, c5_q;
  logic [FracW-1:0]      v0_q;
  logic signed [MW-1:0]  m1_q, m2_q, m3_q, m4_q, m5_q;
  logic [ByteW-1:0]      fb1_q, fb2_q, fb3_q, fb4_q, fb5_q, fb6_q, fb7_q, fb8_q, fb9_q, fb10_q;
  logic [ByteW-1:0]      ob2_q, ob3_q, ob4_q, ob5_q, ob6_q, ob7_q, ob8_q, ob9_q, ob10_q;
  logic [TurnW-1:0]      w3_q, w4_q;
  sector_e               sec4_q, sec5_q, sec6_q, sec7_q, sec8_q, sec9_q, sec10_q;
  logic [UnitW-1:0]      e5_q;
  logic [CW+UnitW-1:0]   ce6_q;
  logic signed [NW-1:0]  mu6_q, n7_q;
  logic [AW-1:0]         a8_q;
  logic                  zero8_q, zero9_q, zero10_q, sat9_q, sat10_q;
  logic [AW2-1:0]        a9_q, rem10_q;
  logic [PW2-1:0]        prod9_q;
  logic [ByteW-1:0]      q10_q;
  logic [ByteW-1:0]      red_q, green_q, blue_q;

  // next-state logic
  logic signed [HpW:0]     hsum;
  logic [HpW-1:0]          hp0_d, q1_d, r2_d, rr;
  logic [2*HpW-1:0]        prod1, qt;
  logic                    pos0_d;
  logic [FracW+ByteW-1:0]  v255;
  logic [ByteW-1:0]        fb1_d, ob2_d, q10_d, xb;
  logic signed [MW-1:0]    m1_d;
  logic signed [MW+7:0]    m255;
  logic [TurnW-1:0]        w3_d, base, tt;
  logic [2:0]              cnt;
  logic signed [TurnW:0]   dif, absd;
  logic [UnitW-1:0]        e5_d;
  logic signed [NW-1:0]    m_ext, mu6_d, n7_d;
  logic signed [NW+7:0]    n255;
  logic [AW-1:0]           a8_d;
  logic                    zero8_d, sat9_d;
  logic [PW2-1:0]          prod9_d;
  logic [AW2-1:0]          qu, rem10_d;
  logic [ByteW-1:0]        red_d, green_d, blue_d;

  // per-stage enables: a stage moves when empty or when the next one moves
  always_comb begin
    en[NS-1] = !vld_q[NS-1] || out_ready_i;
    for (int k = NS - 2; k >= 0; k--) begin
      en[k] = !vld_q[k] || en[k+1];
    end
  end

  assign in_ready_o = en[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (en[0]) begin
        vld_q[0] <= in_valid_i;
      end
      for (int k = 1; k < NS; k++) begin
        if (en[k]) begin
          vld_q[k] <= vld_q[k-1];
        end
      end
    end
  end

  // stage 0: offset hue positive, chroma product
  assign hsum   = (HpW+1)'(hue_i) + $signed((HpW+1)'(Kt * Turn));
  assign hp0_d  = hsum[HpW-1:0];
  assign pos0_d = !hue_i[HueW-1] && (hue_i != '0);

  // stage 1: quotient estimate for hue mod turn, offset, full-channel byte
  assign prod1 = hp0_q * HpW'(Rec1);
  assign q1_d  = prod1[2*HpW-1:HpW];
  assign m1_d  = $signed({2'b00, v0_q, 8'h00}) - $signed({1'b0, c0_q});
  assign v255  = {v0_q, 8'h00} - {8'h00, v0_q};
  assign fb1_d = v255[FracW+ByteW-1] ? ByteMax : v255[FracW+ByteW-2:ByteW];

  // stage 2: remainder, offset-channel byte
  assign qt    = q1_q * HpW'(Turn);
  assign r2_d  = hp1_q - qt[HpW-1:0];
  assign m255  = $signed({m1_q, 8'h00}) - (MW+8)'(m1_q);
  assign ob2_d = (m1_q[MW-1] || m1_q == '0) ? '0 :
                 (|m255[MW+7:24]) ? ByteMax : m255[23:16];

  // stage 3: final correction of the wrap, full turn kept as is
  assign rr   = (r2_q >= HpW'(Turn)) ? r2_q - HpW'(Turn) : r2_q;
  assign w3_d = (rr == '0 && pos2_q) ? TurnW'(Turn) : TurnW'(rr);

  // stage 4: sector by threshold count
  always_comb begin
    cnt = '0;
    for (int k = 1; k < 6; k++) begin
      cnt = cnt + 3'(w3_q >= TurnW'(k * Unit));
    end
  end

  // stage 5: blend weight U - |(h mod 2U) - U|
  always_comb begin
    case (sec4_q)
      SecRY, SecYG: base = '0;
      SecGC, SecCB: base = TurnW'(2 * Unit);
      default:      base = TurnW'(4 * Unit);
    endcase
    tt   = w4_q - base;
    dif  = $signed({1'b0, tt}) - $signed((TurnW+1)'(Unit));
    absd = dif[TurnW] ? -dif : dif;
    e5_d = UnitW'(Unit) - UnitW'(absd);
  end

  // stage 6: products, stage 7: sum
  assign m_ext = NW'(m5_q);
  assign mu6_d = m_ext * $signed(NW'(Unit));
  assign n7_d  = $signed(NW'(ce6_q)) + mu6_q;

  // stage 8: scale by 255 / 2^16
  assign n255    = $signed({n7_q, 8'h00}) - (NW+8)'(n7_q);
  assign a8_d    = n255[16 +: AW];
  assign zero8_d = n7_q[NW-1] || (n7_q == '0);

  // stage 9: saturate check and reciprocal product for / Unit
  assign sat9_d  = a8_q >= AW'(SatLim);
  assign prod9_d = PW2'(a8_q[AW2-1:0] * RecW2'(Rec2));

  // stage 10: quotient estimate and remainder
  assign q10_d   = prod9_q[S2 +: ByteW];
  assign qu      = AW2'(q10_d * AW2'(Unit));
  assign rem10_d = a9_q - qu;

  // stage 11: correct quotient, route channels by sector
  always_comb begin
    if (zero10_q) begin
      xb = '0;
    end else if (sat10_q) begin
      xb = ByteMax;
    end else if (rem10_q >= AW2'(Unit)) begin
      xb = q10_q + ByteW'(1);
    end else begin
      xb = q10_q;
    end
    case (sec10_q)
      SecRY: begin red_d = fb10_q; green_d = xb;     blue_d = ob10_q; end
      SecYG: begin red_d = xb;     green_d = fb10_q; blue_d = ob10_q; end
      SecGC: begin red_d = ob10_q; green_d = fb10_q; blue_d = xb;     end
      SecCB: begin red_d = ob10_q; green_d = xb;     blue_d = fb10_q; end
      SecBM: begin red_d = xb;     green_d = ob10_q; blue_d = fb10_q; end
      default: begin red_d = fb10_q; green_d = ob10_q; blue_d = xb;   end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      hp0_q <= hp0_d; pos0_q <= pos0_d;
      c0_q  <= saturation_i * brightness_i;
      v0_q  <= brightness_i;
    end
    if (en[1]) begin
      q1_q <= q1_d; hp1_q <= hp0_q; pos1_q <= pos0_q;
      c1_q <= c0_q; m1_q <= m1_d; fb1_q <= fb1_d;
    end
    if (en[2]) begin
      r2_q <= r2_d; pos2_q <= pos1_q;
      c2_q <= c1_q; m2_q <= m1_q; fb2_q <= fb1_q; ob2_q <= ob2_d;
    end
    if (en[3]) begin
      w3_q <= w3_d;
      c3_q <= c2_q; m3_q <= m2_q; fb3_q <= fb2_q; ob3_q <= ob2_q;
    end
    if (en[4]) begin
      w4_q <= w3_q; sec4_q <= sector_e'(cnt);
      c4_q <= c3_q; m4_q <= m3_q; fb4_q <= fb3_q; ob4_q <= ob3_q;
    end
    if (en[5]) begin
      e5_q <= e5_d; sec5_q <= sec4_q;
      c5_q <= c4_q; m5_q <= m4_q; fb5_q <= fb4_q; ob5_q <= ob4_q;
    end
    if (en[6]) begin
      ce6_q <= c5_q * e5_q; mu6_q <= mu6_d;
      sec6_q <= sec5_q; fb6_q <= fb5_q; ob6_q <= ob5_q;
    end
    if (en[7]) begin
      n7_q <= n7_d;
      sec7_q <= sec6_q; fb7_q <= fb6_q; ob7_q <= ob6_q;
    end
    if (en[8]) begin
      a8_q <= a8_d; zero8_q <= zero8_d;
      sec8_q <= sec7_q; fb8_q <= fb7_q; ob8_q <= ob7_q;
    end
    if (en[9]) begin
      a9_q <= a8_q[AW2-1:0]; prod9_q <= prod9_d;
      zero9_q <= zero8_q; sat9_q <= sat9_d;
      sec9_q <= sec8_q; fb9_q <= fb8_q; ob9_q <= ob8_q;
    end
    if (en[10]) begin
      q10_q <= q10_d; rem10_q <= rem10_d;
      zero10_q <= zero9_q; sat10_q <= sat9_q;
      sec10_q <= sec9_q; fb10_q <= fb9_q; ob10_q <= ob9_q;
    end
    if (en[11]) begin
      red_q <= red_d; green_q <= green_d; blue_q <= blue_d;
    end
  end

  assign out_valid_o = vld_q[NS-1];
  assign red_o       = red_q;
  assign green_o     = green_q;
  assign blue_o      = blue_q;

  `ASSERT_NOW(a_ready_when_drained, !vld_q[NS-1], in_ready_o)
  `ASSERT_NEXT(a_accept_lands, in_valid_i && in_ready_o, vld_q[0])
  `ASSERT_NOW(a_hue_wrapped, vld_q[3], w3_q <= TurnW'(Turn))
  `ASSERT_NOW(a_blend_range, vld_q[5], e5_q <= UnitW'(Unit))
  `ASSERT_NOW(a_rem_bound, vld_q[10] && !zero10_q && !sat10_q, rem10_q < AW2'(2 * Unit))

endmodule

`default_nettype wire

### tb/tb_top.sv
`timescale 1ns / 100ps
// tb_top - self-checking testbench for hsv_to_rgb_convert_core.
// Uses hsv2rgb_pkg. Predicts each pixel in fixed point and checks it against the output channel,
// with random gaps and stalls on both handshakes.

module tb_top;

  import hsv2rgb_pkg::*;

  localparam int     NumRandom = 1000;
  localparam longint HueSector = longint'(60) << HueFracBitsDef;
  localparam longint HueTurn   = longint'(360) << HueFracBitsDef;
  localparam longint ChanDenom = longint'(65536) * HueSector;
  localparam int     DrainTail = 40;

  typedef enum int {
    SecRedYellow, SecYellowGreen, SecGreenCyan, SecCyanBlue, SecBlueMagenta, SecMagentaRed
  } hue_sector_e;

  typedef struct {
    logic signed [HueW-1:0]  hue;
    logic        [FracW-1:0] sat;
    logic        [FracW-1:0] val;
    bit                      drain;
  } hsv_req_t;

  typedef struct {
    logic [ByteW-1:0] red;
    logic [ByteW-1:0] green;
    logic [ByteW-1:0] blue;
  } pixel_t;

  logic                    clk_i        = 1'b0;
  logic                    rst_ni       = 1'b0;
  logic                    in_valid_i   = 1'b0;
  logic                    in_ready_o;
  logic signed [HueW-1:0]  hue_i        = '0;
  logic        [FracW-1:0] saturation_i = '0;
  logic        [FracW-1:0] brightness_i = '0;
  logic                    out_valid_o;
  logic                    out_ready_i  = 1'b0;
  logic        [ByteW-1:0] red_o;
  logic        [ByteW-1:0] green_o;
  logic        [ByteW-1:0] blue_o;

  hsv_req_t hsv_pending_q[$];
  pixel_t   pixel_expect_q[$];
  int       n_accepted = 0;
  int       n_checked  = 0;
  int       n_errors   = 0;
  int       send_gap   = 0;
  int       recv_stall = 0;
  bit       send_calm  = 1'b0;
  bit       recv_calm  = 1'b0;
  int       n_wide_hue = 0;
  int       n_over_one = 0;
  int       n_drains   = 0;

  hsv_to_rgb_convert_core u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .hue_i        (hue_i),
    .saturation_i (saturation_i),
    .brightness_i (brightness_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .red_o        (red_o),
    .green_o      (green_o),
    .blue_o       (blue_o)
  );

  function automatic logic [ByteW-1:0] scaled_to_byte(input longint scaled);
    longint v;
    if (scaled <= 0) return '0;
    v = (scaled * 255) / ChanDenom;
    if (v > 255) v = 255;
    return v[ByteW-1:0];
  endfunction

  function automatic pixel_t hsv_to_pixel(input logic signed [HueW-1:0] hue,
                                          input logic [FracW-1:0] sat,
                                          input logic [FracW-1:0] val);
    longint      h, c, m, t, d, cs, ms, xs, r, g, b, sec;
    hue_sector_e sector;
    pixel_t      px;
    h = hue;
    if (h < 0) begin
      h = h % HueTurn;
      if (h < 0) h += HueTurn;
    end
    if (h > HueTurn) begin
      h = h % HueTurn;
      if (h == 0) h = HueTurn;
    end
    c = longint'(val) * longint'(sat);
    m = longint'(val) * 256 - c;
    t = h % (2 * HueSector);
    d = t - HueSector;
    if (d < 0) d = -d;
    cs = c * HueSector;
    ms = m * HueSector;
    xs = c * (HueSector - d);
    sec = h / HueSector;
    if (sec > 5) sec = 5;
    sector = hue_sector_e'(sec);
    case (sector)
      SecRedYellow: begin r = cs; g = xs; b = 0; end
      SecYellowGreen: begin r = xs; g = cs; b = 0; end
      SecGreenCyan: begin r = 0; g = cs; b = xs; end
      SecCyanBlue: begin r = 0; g = xs; b = cs; end
      SecBlueMagenta: begin r = xs; g = 0; b = cs; end
      default: begin r = cs; g = 0; b = xs; end
    endcase
    px.red   = scaled_to_byte(r + ms);
    px.green = scaled_to_byte(g + ms);
    px.blue  = scaled_to_byte(b + ms);
    return px;
  endfunction

  // mostly no gap, some short, a few long
  function automatic int pick_gap(input bit calm);
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic add_req(input int hue, input int sat, input int val, input bit drain);
    hsv_req_t req;
    req.hue   = hue[HueW-1:0];
    req.sat   = sat[FracW-1:0];
    req.val   = val[FracW-1:0];
    req.drain = drain;
    if (req.hue < -longint'(HueTurn) || req.hue >= 2 * HueTurn) n_wide_hue++;
    if (req.sat > 256 || req.val > 256) n_over_one++;
    if (drain) n_drains++;
    hsv_pending_q.push_back(req);
  endtask

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #20_000_000;
    $display("tb_top: FAIL");
    $finish;
  end

  // request driver
  always @(posedge clk_i or negedge rst_ni) begin : drive_p
    int       in_flight;
    hsv_req_t req;
    if (!rst_ni) begin
      in_valid_i   <= 1'b0;
      hue_i        <= '0;
      saturation_i <= '0;
      brightness_i <= '0;
      send_gap     <= 0;
    end else begin
      if ($urandom_range(0, 99) == 0) send_calm <= !send_calm;
      in_flight = n_accepted - n_checked + ((in_valid_i && in_ready_o) ? 1 : 0);
      if (!in_valid_i || in_ready_o) begin
        if (send_gap != 0) begin
          in_valid_i <= 1'b0;
          send_gap   <= send_gap - 1;
        end else if (hsv_pending_q.size() != 0 &&
                     !(hsv_pending_q[0].drain && in_flight != 0)) begin
          req = hsv_pending_q.pop_front();
          hue_i        <= req.hue;
          saturation_i <= req.sat;
          brightness_i <= req.val;
          in_valid_i   <= 1'b1;
          send_gap     <= pick_gap(send_calm);
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // pixel receiver back-pressure
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      recv_stall  <= 0;
    end else begin
      if ($urandom_range(0, 99) == 0) recv_calm <= !recv_calm;
      if (recv_stall != 0) begin
        out_ready_i <= 1'b0;
        recv_stall  <= recv_stall - 1;
      end else begin
        out_ready_i <= 1'b1;
        recv_stall  <= pick_gap(recv_calm);
      end
    end
  end

  // monitor: predict on request accept, check on pixel accept
  always @(posedge clk_i) begin : monitor_p
    pixel_t exp_px;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        pixel_expect_q.push_back(hsv_to_pixel(hue_i, saturation_i, brightness_i));
        n_accepted <= n_accepted + 1;
      end
      if (out_valid_o && out_ready_i) begin
        n_checked <= n_checked + 1;
        if (pixel_expect_q.size() == 0) begin
          $display("%0t: unexpected pixel r=%0d g=%0d b=%0d", $time, red_o, green_o, blue_o);
          n_errors++;
        end else begin
          exp_px = pixel_expect_q.pop_front();
          if (red_o !== exp_px.red) begin
            $display("%0t: red mismatch exp %0d got %0d", $time, exp_px.red, red_o);
            n_errors++;
          end
          if (green_o !== exp_px.green) begin
            $display("%0t: green mismatch exp %0d got %0d", $time, exp_px.green, green_o);
            n_errors++;
          end
          if (blue_o !== exp_px.blue) begin
            $display("%0t: blue mismatch exp %0d got %0d", $time, exp_px.blue, blue_o);
            n_errors++;
          end
        end
      end
    end
  end

  initial begin : stim_p
    int k, hue, sat, val, pick;
    // sector edges at full saturation and brightness
    add_req(0, 256, 256, 1'b0);
    add_req(3840, 256, 256, 1'b0);
    add_req(7680, 256, 256, 1'b0);
    add_req(11520, 256, 256, 1'b0);
    add_req(15360, 256, 256, 1'b0);
    add_req(19200, 256, 256, 1'b0);
    add_req(23040, 256, 256, 1'b0);
    add_req(23041, 256, 256, 1'b0);
    add_req(1919, 256, 256, 1'b0);
    add_req(22999, 256, 256, 1'b0);
    // hue wrapping, in range and beyond
    add_req(-23040, 200, 180, 1'b0);
    add_req(-1, 256, 256, 1'b0);
    add_req(46079, 256, 256, 1'b0);
    add_req(46080, 128, 200, 1'b0);
    add_req(-65536, 511, 511, 1'b0);
    add_req(65535, 0, 511, 1'b0);
    // saturation and brightness extremes, negative offset
    add_req(0, 0, 0, 1'b0);
    add_req(5000, 0, 256, 1'b0);
    add_req(5000, 256, 0, 1'b0);
    add_req(5000, 511, 511, 1'b0);
    add_req(5000, 511, 256, 1'b0);
    add_req(12000, 300, 200, 1'b0);
    add_req(9999, 255, 255, 1'b0);
    for (k = 0; k < NumRandom; k++) begin
      pick = $urandom_range(0, 99);
      if (pick < 15) begin
        hue = $urandom_range(0, 131071);
        if (hue > 65535) hue -= 131072;
      end else if (pick < 35) begin
        hue = 3840 * (int'($urandom_range(0, 18)) - 6) + int'($urandom_range(0, 6)) - 3;
      end else begin
        hue = $urandom_range(0, 69119) - 23040;
      end
      if ($urandom_range(0, 99) < 15) begin
        sat = $urandom_range(0, 511);
        val = $urandom_range(0, 511);
      end else begin
        sat = $urandom_range(0, 256);
        val = $urandom_range(0, 256);
      end
      add_req(hue, sat, val, (k % 250) == 0);
    end

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    do @(posedge clk_i); while (hsv_pending_q.size() != 0 || in_valid_i);
    do @(posedge clk_i); while (n_accepted != n_checked);
    repeat (DrainTail) @(posedge clk_i);
    if (pixel_expect_q.size() != 0) begin
      $display("%0t: %0d pixels never arrived", $time, pixel_expect_q.size());
      n_errors++;
    end

    $display("Converted %0d pixels: %0d with hue outside -360..720, %0d with s or v above 1.0.",
             n_checked, n_wide_hue, n_over_one);
    $display("Sender drained the pipeline %0d times; %0d errors.", n_drains, n_errors);
    if (n_errors == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
